/* src/lss_pkg.sv */
// Shared types and constants for the five-point Laplacian stencil stream unit.
// No dependencies; imported by the top level and its checker.
package lss_pkg;

    localparam int DATA_W      = 32;   // Q16.16 sample and result width
    localparam int COORD_W     = 10;   // reported column and row index width
    localparam int GEOM_W      = 11;   // grid_width and grid_height register width
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = 56;   // result, column, row packed to whole bytes

    localparam logic [GEOM_W-1:0] MIN_EXTENT   = 11'd3;
    localparam logic [GEOM_W-1:0] HEIGHT_LIMIT = 11'd1024;

    localparam logic [GEOM_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GEOM_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
    localparam logic [DATA_W-1:0]  INV_SPACING_RST = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_INV_SPACING = 2'd2
    } t_cfg_reg;

endpackage

/* src/laplacian_stencil_stream_unit.sv */
// Five-point Laplacian over a raster-order sample stream, with line store and window.
// Depends on lss_pkg and lss_ram.
//
// Accepts one signed Q16.16 sample per cycle unless stalled, column fastest, over a
// grid_width x grid_height frame, and emits the saturated Q16.16 Laplacian of
// every interior point, tagged with its column and row; tlast marks the last
// interior point of the frame. The sample at (c, r) with c >= 2 and r >= 2
// yields the point (c-1, r-1); boundary samples yield nothing. Sustained rate
// is one sample per cycle while the result stream accepts. A sample that
// completes a stencil passes through the registered stages line-store read,
// neighbour sum, split multiply, and round and saturate. The two previous
// rows live in two RAM banks of MAX_WIDTH words each, picked by row parity;
// they need no clearing after reset. Writing grid_width or grid_height
// restarts the frame at (0, 0); configure only while the unit is idle.
module laplacian_stencil_stream_unit
    import lss_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SPACE_DIMS  = 2,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_W-1:0]      i_cfg_data,
    // sample stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [DATA_W-1:0]      i_s_tdata,   // [31:0] sample_value
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [31:0] laplacian_value,
                                                // [41:32] centre_column,
                                                // [51:42] centre_row, [55:52] zero
    output logic                   o_m_tlast    // frame_last
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W   = (COL_W + 1 > GEOM_W) ? COL_W + 1 : GEOM_W;
    localparam int ROW_W   = COORD_W;
    localparam int SEXT_W  = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
    localparam int SEXT_SH = DATA_W - SEXT_W;
    localparam int COEF    = 2 * SPACE_DIMS;
    localparam int SUM_W   = DATA_W + 4;
    localparam int PROD_W  = SUM_W + 17;

    localparam logic signed [PROD_W-1:0] ROUND   = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(64'sh8000_0000));
    localparam logic signed [SUM_W-1:0]  COEF_S  = SUM_W'(COEF);

    // configuration
    logic [GEOM_W-1:0] r_grid_width;
    logic [GEOM_W-1:0] r_grid_height;
    logic [DATA_W-1:0] r_inv_spacing;
    logic              cfg_fire;
    logic              geom_write;

    // frame position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  eff_width;
    logic [GEOM_W-1:0] eff_height;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;

    // handshake
    logic in_fire;
    logic s1_take;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    // stage 1: line-store read in flight
    logic               r_v1;
    logic               r_prod1;
    logic               r_last1;
    logic               r_bank1;
    logic signed [DATA_W-1:0] r_x1;
    logic [COORD_W-1:0] r_col1;
    logic [COORD_W-1:0] r_row1;

    logic signed [DATA_W-1:0] x_shl;
    logic signed [DATA_W-1:0] x_in;
    logic [DATA_W-1:0]  bank0_rdata;
    logic [DATA_W-1:0]  bank1_rdata;
    logic signed [DATA_W-1:0] top_c;
    logic signed [DATA_W-1:0] mid_c;

    // window: left, centre, top, bottom (right is the fresh middle-row read)
    logic signed [DATA_W-1:0] r_win_left;
    logic signed [DATA_W-1:0] r_win_centre;
    logic signed [DATA_W-1:0] r_win_top;
    logic signed [DATA_W-1:0] r_win_bottom;
    logic signed [SUM_W-1:0]  n_sum;

    // stage 2: neighbour sum
    logic                    r_v2;
    logic signed [SUM_W-1:0] r_sum;
    logic [COORD_W-1:0]      r_col2;
    logic [COORD_W-1:0]      r_row2;
    logic                    r_last2;

    // stage 3: partial products
    logic                     r_v3;
    logic signed [PROD_W-1:0] r_phi;
    logic signed [PROD_W-1:0] r_plo;
    logic [COORD_W-1:0]       r_col3;
    logic [COORD_W-1:0]       r_row3;
    logic                     r_last3;
    logic signed [16:0]       k_hi;
    logic signed [16:0]       k_lo;

    // stage 4: output register
    logic                     r_v4;
    logic [DATA_W-1:0]        r_lap;
    logic [COORD_W-1:0]       r_col4;
    logic [COORD_W-1:0]       r_row4;
    logic                     r_last4;
    logic signed [PROD_W-1:0] scaled;
    logic [DATA_W-1:0]        n_lap;

    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_m1;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign geom_write  = cfg_fire && ((t_cfg_reg'(i_cfg_index) == REG_GRID_WIDTH) ||
                                      (t_cfg_reg'(i_cfg_index) == REG_GRID_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_inv_spacing <= INV_SPACING_RST;
        end else if (cfg_fire) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GEOM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GEOM_W-1:0];
                REG_INV_SPACING: r_inv_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb begin
        width_ext = CMP_W'(r_grid_width);
        if (width_ext < CMP_W'(MIN_EXTENT)) begin
            eff_width = CMP_W'(MIN_EXTENT);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        if (r_grid_height < MIN_EXTENT) begin
            eff_height = MIN_EXTENT;
        end else if (r_grid_height > HEIGHT_LIMIT) begin
            eff_height = HEIGHT_LIMIT;
        end else begin
            eff_height = r_grid_height;
        end
    end

    assign last_col = COL_W'(eff_width - CMP_W'(1));
    assign last_row = ROW_W'(eff_height - GEOM_W'(1));

    // ---------------- handshake ----------------
    assign rdy4    = !r_v4 || i_m_tready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign s1_take = r_v1 && (!r_prod1 || rdy2);
    assign rdy1    = !r_v1 || s1_take;

    assign o_s_tready = rdy1;
    assign in_fire    = i_s_tvalid && rdy1;

    // ---------------- frame position ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_write) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (r_col == last_col) begin
                r_col <= '0;
                r_row <= (r_row == last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ---------------- line store ----------------
    assign x_shl = i_s_tdata << SEXT_SH;
    assign x_in  = x_shl >>> SEXT_SH;

    lss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (in_fire && !r_row[0]),
        .i_waddr (r_col),
        .i_wdata (x_in),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (bank0_rdata)
    );

    lss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (in_fire && r_row[0]),
        .i_waddr (r_col),
        .i_wdata (x_in),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (bank1_rdata)
    );

    assign col_m1 = r_col - COL_W'(1);
    assign row_m1 = r_row - ROW_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= in_fire || (r_v1 && !s1_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x1    <= x_in;
            r_bank1 <= r_row[0];
            r_prod1 <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_last1 <= (r_col == last_col) && (r_row == last_row);
            r_col1  <= COORD_W'(col_m1);
            r_row1  <= COORD_W'(row_m1);
        end
    end

    // older bank holds row r-2, the other row r-1
    assign top_c = r_bank1 ? bank1_rdata : bank0_rdata;
    assign mid_c = r_bank1 ? bank0_rdata : bank1_rdata;

    // ---------------- window and neighbour sum ----------------
    always_comb begin
        n_sum = SUM_W'(r_win_left) + SUM_W'(mid_c);
        if (SPACE_DIMS >= 2) begin
            n_sum = n_sum + SUM_W'(r_win_top) + SUM_W'(r_win_bottom);
        end
        n_sum = n_sum - COEF_S * SUM_W'(r_win_centre);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_centre <= '0;
            r_win_top    <= '0;
            r_win_bottom <= '0;
        end else if (s1_take) begin
            r_win_left   <= r_win_centre;
            r_win_centre <= mid_c;
            r_win_top    <= top_c;
            r_win_bottom <= r_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= (s1_take && r_prod1) || (r_v2 && !rdy3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && r_prod1) begin
            r_sum   <= n_sum;
            r_col2  <= r_col1;
            r_row2  <= r_row1;
            r_last2 <= r_last1;
        end
    end

    // ---------------- scale: split the 32-bit factor into halves ----------------
    assign k_hi = {1'b0, r_inv_spacing[31:16]};
    assign k_lo = {1'b0, r_inv_spacing[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= (r_v2 && rdy3) || (r_v3 && !rdy4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_phi   <= PROD_W'(r_sum) * PROD_W'(k_hi);
            r_plo   <= PROD_W'(r_sum) * PROD_W'(k_lo) + ROUND;
            r_col3  <= r_col2;
            r_row3  <= r_row2;
            r_last3 <= r_last2;
        end
    end

    // round to nearest, then saturate to 32 bits
    always_comb begin
        scaled = r_phi + (r_plo >>> 16);
        if (scaled > SAT_MAX) begin
            n_lap = SAT_MAX[DATA_W-1:0];
        end else if (scaled < SAT_MIN) begin
            n_lap = SAT_MIN[DATA_W-1:0];
        end else begin
            n_lap = scaled[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= (r_v3 && rdy4) || (r_v4 && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            r_lap   <= n_lap;
            r_col4  <= r_col3;
            r_row4  <= r_row3;
            r_last4 <= r_last3;
        end
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {4'b0000, r_row4, r_col4, r_lap};
    assign o_m_tlast  = r_last4;

endmodule

/* src/lss_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first: a read of the address being written returns the old content.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lss_checker.sv */
// Port-level checker for laplacian_stencil_stream_unit, bound to the top level.
// Depends on lss_pkg for field widths.
module lss_checker
    import lss_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast
);

    // a held result keeps its payload
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // reported points are never on the top or left boundary
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DATA_W+COORD_W-1:DATA_W] != '0) &&
                       (o_m_tdata[DATA_W+2*COORD_W-1:DATA_W+COORD_W] != '0))
        else $error("boundary point reported");

    // with the output free an offered sample must be taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with output free");

    // reset leaves no result pending
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind laplacian_stencil_stream_unit lss_checker u_lss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
